@@ rtl/rvsq_pkg.sv @@
// ----------------------------------------------------------------------------
// rvsq_pkg
// Types and codes shared by the residual-voltage safety qualifier.
// ----------------------------------------------------------------------------
package rvsq_pkg;

	// Widths of the item fields and registers
	localparam int unsigned MvW    = 16;
	localparam int unsigned MagW   = 17;
	localparam int unsigned ThrW   = 15;
	localparam int unsigned CountW = 8;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 15;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_RELEASE_THR  = 2'd0,
		CFG_BLOCK_THR    = 2'd1,
		CFG_REQ_COUNT    = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	// Reset values of the registers
	localparam logic [ThrW-1:0]   ReleaseThrRst = ThrW'(100);
	localparam logic [ThrW-1:0]   BlockThrRst   = ThrW'(1000);
	localparam logic [CountW-1:0] ReqCountRst   = CountW'(8);

	// Reported safety state
	typedef enum logic [1:0] {
		ST_UNKNOWN   = 2'd0,
		ST_SATURATED = 2'd1,
		ST_UNSAFE    = 2'd2,
		ST_SAFE      = 2'd3
	} safety_state_t;

	typedef struct packed {
		logic                  sample_valid;
		logic                  adc_saturated;
		logic signed [MvW-1:0] high_node_mv;
		logic signed [MvW-1:0] low_node_mv;
		logic signed [MvW-1:0] diff_mv;
	} meas_item_t;

	typedef struct packed {
		logic [1:0] safety_state;
	} result_item_t;

	typedef struct packed {
		logic [ThrW-1:0]   release_thr;
		logic [ThrW-1:0]   block_thr;
		logic [CountW-1:0] req_count;
	} cfg_t;

	typedef struct packed {
		logic [CountW-1:0] run_count;
		safety_state_t     state;
	} qual_state_t;

	// Exact magnitude of a signed 16-bit reading in 17 bits
	function automatic logic [MagW-1:0] mag17(input logic signed [MvW-1:0] v);
		logic signed [MagW-1:0] ext;
		ext = MagW'(v);
		return v[MvW-1] ? MagW'(-ext) : MagW'(ext);
	endfunction

endpackage

@@ rtl/rvsq_meas_if.sv @@
// ----------------------------------------------------------------------------
// rvsq_meas_if
// Valid/ready channel that carries one measurement item.
// ----------------------------------------------------------------------------
interface rvsq_meas_if;
	import rvsq_pkg::*;

	logic       valid;
	logic       ready;
	meas_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rvsq_result_if.sv @@
// ----------------------------------------------------------------------------
// rvsq_result_if
// Valid/ready channel that carries one safety-state result item.
// ----------------------------------------------------------------------------
interface rvsq_result_if;
	import rvsq_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rvsq_rule.sv @@
// ----------------------------------------------------------------------------
// rvsq_rule
// Applies the qualification rules to one measurement and the current state,
// giving the next run count and the next safety state.
// ----------------------------------------------------------------------------
module rvsq_rule (
	input  rvsq_pkg::meas_item_t  item,
	input  rvsq_pkg::cfg_t        cfg,
	input  rvsq_pkg::qual_state_t cur,
	output rvsq_pkg::qual_state_t nxt
);
	import rvsq_pkg::*;

	logic [MagW-1:0]   mag_hi;
	logic [MagW-1:0]   mag_lo;
	logic [MagW-1:0]   mag_diff;
	logic [MagW-1:0]   block_thr;
	logic [MagW-1:0]   release_thr;
	logic              any_block;
	logic              all_release;
	logic [CountW-1:0] count_adv;

	// Form magnitudes and compare against both thresholds
	assign mag_hi      = mag17(item.high_node_mv);
	assign mag_lo      = mag17(item.low_node_mv);
	assign mag_diff    = mag17(item.diff_mv);
	assign block_thr   = MagW'(cfg.block_thr);
	assign release_thr = MagW'(cfg.release_thr);

	assign any_block   = (mag_hi >= block_thr) || (mag_lo >= block_thr) ||
	                     (mag_diff >= block_thr);
	assign all_release = (mag_hi <= release_thr) && (mag_lo <= release_thr) &&
	                     (mag_diff <= release_thr);

	// Advance the run count until it meets the required count
	assign count_adv = (cur.run_count < cfg.req_count) ?
	                   cur.run_count + CountW'(1) : cur.run_count;

	// Apply the rules in priority order
	always_comb begin
		priority if (!item.sample_valid) begin
			nxt.run_count = '0;
			nxt.state     = ST_UNKNOWN;
		end else if (item.adc_saturated) begin
			nxt.run_count = '0;
			nxt.state     = ST_SATURATED;
		end else if (any_block) begin
			nxt.run_count = '0;
			nxt.state     = ST_UNSAFE;
		end else if (all_release) begin
			nxt.run_count = count_adv;
			nxt.state     = (count_adv >= cfg.req_count) ? ST_SAFE : ST_UNKNOWN;
		end else begin
			nxt.run_count = '0;
			nxt.state     = (cur.state == ST_SAFE) ? ST_SAFE : ST_UNKNOWN;
		end
	end

endmodule

@@ rtl/residual_voltage_safety_qualifier_top.sv @@
// A result item is offered from the result register once its measurement leaves the
// input register. Throughput: one item per cycle while the result sink is ready.
// Input and result registers part the two sides, so a new item is taken into an
// empty input register while a finished result still waits for its sink.
// Reset (arst_n low, asynchronous): thresholds 100 mV / 1000 mV, required count 8,
// run count zero, state unknown, both stages empty.
// ----------------------------------------------------------------------------
// residual_voltage_safety_qualifier_top
// Qualifies residual-voltage measurements into a safety state with hysteresis
// thresholds and a consecutive-safe-sample count.
// ----------------------------------------------------------------------------
module residual_voltage_safety_qualifier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rvsq_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [rvsq_pkg::CfgDataW-1:0]   cfg_data,
	rvsq_meas_if.sink                       meas,
	rvsq_result_if.source                   result
);
	import rvsq_pkg::*;

	cfg_t         cfg_q;
	qual_state_t  state_q;
	qual_state_t  state_nxt;
	meas_item_t   item_s1;
	logic         valid_s1;
	result_item_t res_s2;
	logic         valid_s2;
	logic         advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_thr <= ReleaseThrRst;
			cfg_q.block_thr   <= BlockThrRst;
			cfg_q.req_count   <= ReqCountRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_RELEASE_THR: cfg_q.release_thr <= cfg_data[ThrW-1:0];
				CFG_BLOCK_THR:   cfg_q.block_thr   <= cfg_data[ThrW-1:0];
				CFG_REQ_COUNT:   cfg_q.req_count   <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the result register is free or being drained
	assign advance    = !valid_s2 || result.ready;
	assign meas.ready = !valid_s1 || advance;

	// Hold the accepted item in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas.ready && meas.valid) begin
			item_s1 <= meas.data;
		end
	end

	rvsq_rule u_rule (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// Update the qualifier state and the result register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.run_count <= '0;
			state_q.state     <= ST_UNKNOWN;
			valid_s2          <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2.safety_state <= state_nxt.state;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the residual-voltage safety qualifier. A short
// table of directed measurements covers the field extremes, every rule and
// the count corner cases around register changes. Random phases with fresh
// register settings follow. Every result is checked in order, against the
// table's expected state for typed rows and an in-bench model of the
// qualifier otherwise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import rvsq_pkg::*;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		cfg_idx_t            idx;
		logic [CfgDataW-1:0] val;
		meas_item_t          item;
		bit                  typed;
		safety_state_t       want;
	} stim_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                cfg_we   = 1'b0;
	cfg_idx_t            cfg_idx  = CFG_RELEASE_THR;
	logic [CfgDataW-1:0] cfg_data = '0;

	rvsq_meas_if   meas_ch();
	rvsq_result_if res_ch();

	residual_voltage_safety_qualifier_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.meas     (meas_ch),
		.result   (res_ch)
	);

	// Qualifier model: register copies and running state
	logic [ThrW-1:0]   rel_thr;
	logic [ThrW-1:0]   blk_thr;
	logic [CountW-1:0] req_cnt;
	logic [CountW-1:0] run_cnt;
	safety_state_t     qual_state;

	// Expected safety states, oldest first
	safety_state_t state_q[$];

	// Typed expectation that travels with the item on the wire
	bit            drv_typed = 1'b0;
	safety_state_t drv_want  = ST_UNKNOWN;

	bit idle_tx = 1'b1;
	bit idle_rx = 1'b1;

	int errors    = 0;
	int n_items   = 0;
	int n_results = 0;
	int n_writes  = 0;
	int n_by_state[4];

	always #5 clk = ~clk;

	// Exact magnitude of a signed millivolt reading
	function automatic logic [MagW-1:0] abs_mv(logic signed [MvW-1:0] v);
		return v[MvW-1] ? MagW'(17'h10000 - {1'b0, v}) : {1'b0, v};
	endfunction

	// Advance the model by one measurement and return the reported state
	function automatic safety_state_t qualify_sample(meas_item_t it);
		logic [MagW-1:0] mh, ml, md;
		mh = abs_mv(it.high_node_mv);
		ml = abs_mv(it.low_node_mv);
		md = abs_mv(it.diff_mv);
		if (!it.sample_valid) begin
			run_cnt    = '0;
			qual_state = ST_UNKNOWN;
		end else if (it.adc_saturated) begin
			run_cnt    = '0;
			qual_state = ST_SATURATED;
		end else if (mh >= blk_thr || ml >= blk_thr || md >= blk_thr) begin
			run_cnt    = '0;
			qual_state = ST_UNSAFE;
		end else if (mh <= rel_thr && ml <= rel_thr && md <= rel_thr) begin
			if (run_cnt < req_cnt)
				run_cnt = run_cnt + 1'b1;
			qual_state = (run_cnt >= req_cnt) ? ST_SAFE : ST_UNKNOWN;
		end else begin
			run_cnt = '0;
			if (qual_state != ST_SAFE)
				qual_state = ST_UNKNOWN;
		end
		return qual_state;
	endfunction

	function automatic stim_row_t meas_row(bit v, bit s, int h, int l, int d,
			bit typed, safety_state_t want);
		stim_row_t r;
		r.kind                = ROW_ITEM;
		r.idx                 = CFG_RELEASE_THR;
		r.val                 = '0;
		r.item.sample_valid   = v;
		r.item.adc_saturated  = s;
		r.item.high_node_mv   = MvW'(h);
		r.item.low_node_mv    = MvW'(l);
		r.item.diff_mv        = MvW'(d);
		r.typed               = typed;
		r.want                = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t idx, int val);
		stim_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.val   = CfgDataW'(val);
		r.item  = '0;
		r.typed = 1'b0;
		r.want  = ST_UNKNOWN;
		return r;
	endfunction

	// Reading with a magnitude in [lo, hi] and a random sign
	function automatic logic [MvW-1:0] pick_mv(int lo, int hi);
		int m;
		m = $urandom_range(hi, lo);
		if (m == 32768 || (m != 0 && $urandom_range(0, 1) == 1))
			return MvW'(-m);
		return MvW'(m);
	endfunction

	// Random measurement shaped by the current thresholds
	function automatic meas_item_t make_meas(int safe_pct);
		meas_item_t it;
		int         safe_hi, hot_lo, hot_hi;
		it.sample_valid  = 1'b1;
		it.adc_saturated = 1'b0;
		it.high_node_mv  = MvW'($urandom());
		it.low_node_mv   = MvW'($urandom());
		it.diff_mv       = MvW'($urandom());
		// the block check wins, so a safe reading must also stay under it
		safe_hi = (int'(rel_thr) < int'(blk_thr)) ? int'(rel_thr) : int'(blk_thr) - 1;
		hot_lo  = -1;
		hot_hi  = 0;
		if ($urandom_range(0, 99) < safe_pct) begin
			if (safe_hi >= 0) begin
				it.high_node_mv = pick_mv(0, safe_hi);
				it.low_node_mv  = pick_mv(0, safe_hi);
				it.diff_mv      = pick_mv(0, safe_hi);
			end
		end else begin
			case ($urandom_range(0, 5))
				0, 1: begin
					if (safe_hi >= 0) begin
						it.high_node_mv = pick_mv(0, safe_hi);
						it.low_node_mv  = pick_mv(0, safe_hi);
						it.diff_mv      = pick_mv(0, safe_hi);
					end
					if (int'(rel_thr) + 1 <= int'(blk_thr) - 1) begin
						hot_lo = int'(rel_thr) + 1;
						hot_hi = int'(blk_thr) - 1;
					end
				end
				2: begin
					hot_lo = int'(blk_thr);
					hot_hi = 32768;
				end
				3: it.adc_saturated = 1'b1;
				4: begin
					it.sample_valid  = 1'b0;
					it.adc_saturated = 1'($urandom_range(0, 1));
				end
				default: begin
					it.sample_valid  = 1'($urandom_range(0, 1));
					it.adc_saturated = 1'($urandom_range(0, 1));
				end
			endcase
		end
		// put one reading into the band or over the block threshold
		if (hot_lo >= 0) begin
			case ($urandom_range(0, 2))
				0: it.high_node_mv = pick_mv(hot_lo, hot_hi);
				1: it.low_node_mv  = pick_mv(hot_lo, hot_hi);
				default: it.diff_mv = pick_mv(hot_lo, hot_hi);
			endcase
		end
		return it;
	endfunction

	// Offer one measurement after a random gap; return at the falling edge
	task automatic send_meas(meas_item_t it, bit typed, safety_state_t want);
		int gap;
		gap = idle_tx ? $urandom_range(0, 17) : 0;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			meas_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.data  <= it;
		drv_typed     <= typed;
		drv_want      <= want;
		do @(posedge clk); while (!meas_ch.ready);
		@(negedge clk);
	endtask

	// Hold off input until every expected result has arrived
	task automatic wait_drained();
		meas_ch.valid <= 1'b0;
		cfg_we        <= 1'b0;
		while (state_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register; the write enable drops with the next item or drain
	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		case (idx)
			CFG_RELEASE_THR: rel_thr = val[ThrW-1:0];
			CFG_BLOCK_THR:   blk_thr = val[ThrW-1:0];
			CFG_REQ_COUNT:   req_cnt = val[CountW-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	// Predict on accepted items, check accepted results
	always @(posedge clk) begin
		safety_state_t want;
		if (arst_n) begin
			if (meas_ch.valid && meas_ch.ready) begin
				want = qualify_sample(meas_ch.data);
				if (drv_typed)
					want = drv_want;
				state_q.push_back(want);
				n_items++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (state_q.size() == 0) begin
					errors++;
					if (errors <= 200)
						$display("%0t: unexpected result, expected none, actual %0d",
							$time, res_ch.data.safety_state);
				end else begin
					want = state_q.pop_front();
					n_results++;
					if (res_ch.data.safety_state !== want) begin
						errors++;
						if (errors <= 200)
							$display("%0t: safety_state mismatch, expected %0d, actual %0d",
								$time, want, res_ch.data.safety_state);
					end else begin
						n_by_state[want]++;
					end
				end
			end
		end
	end

	// Result sink with random stalls
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_rx ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Stimulus
	initial begin
		stim_row_t tbl[$];
		int        i, phase, n_phase, safe_pct, rel, blk, req;
		meas_ch.valid = 1'b0;
		meas_ch.data  = '0;
		rel_thr    = ReleaseThrRst;
		blk_thr    = BlockThrRst;
		req_cnt    = ReqCountRst;
		run_cnt    = '0;
		qual_state = ST_UNKNOWN;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, reset thresholds 100 / 1000 mV and count 8
		tbl.push_back(meas_row(0, 1, 32767, -32768, -32768, 1, ST_UNKNOWN));
		tbl.push_back(meas_row(1, 1, -32768, 32767, 0, 1, ST_SATURATED));
		tbl.push_back(meas_row(1, 0, -32768, 0, 0, 1, ST_UNSAFE));
		tbl.push_back(meas_row(1, 0, 0, 0, 1000, 1, ST_UNSAFE));
		tbl.push_back(meas_row(1, 0, 0, -1000, 0, 1, ST_UNSAFE));
		tbl.push_back(meas_row(1, 0, 999, 0, -999, 1, ST_UNKNOWN));
		// seven safe samples at the release edge, then safe on the eighth
		for (i = 0; i < 7; i++)
			tbl.push_back(meas_row(1, 0, 100, -100, -100, 1, ST_UNKNOWN));
		tbl.push_back(meas_row(1, 0, 0, 0, 0, 1, ST_SAFE));
		// band reading clears the count but keeps safe
		tbl.push_back(meas_row(1, 0, 0, 101, 0, 1, ST_SAFE));
		tbl.push_back(meas_row(1, 0, -5, 5, 0, 1, ST_UNKNOWN));
		for (i = 0; i < 3; i++)
			tbl.push_back(meas_row(1, 0, 37, -64, 12, 0, ST_UNKNOWN));
		// unused index leaves everything alone; lower count under the run
		tbl.push_back(cfg_row(CFG_UNUSED, 7));
		tbl.push_back(cfg_row(CFG_REQ_COUNT, 2));
		tbl.push_back(meas_row(1, 0, 1, 1, 1, 1, ST_SAFE));
		// zero required count gives safe at once
		tbl.push_back(cfg_row(CFG_REQ_COUNT, 0));
		tbl.push_back(meas_row(1, 0, -100, 0, 100, 1, ST_SAFE));
		// raise required count above the run
		tbl.push_back(cfg_row(CFG_REQ_COUNT, 6));
		tbl.push_back(meas_row(1, 0, 0, 0, -1, 1, ST_UNKNOWN));
		tbl.push_back(meas_row(1, 0, 2, -3, 4, 1, ST_SAFE));
		// release above block: block check comes first
		tbl.push_back(cfg_row(CFG_RELEASE_THR, 500));
		tbl.push_back(cfg_row(CFG_BLOCK_THR, 200));
		tbl.push_back(meas_row(1, 0, 300, 0, 0, 1, ST_UNSAFE));
		tbl.push_back(meas_row(1, 0, 150, -150, 199, 0, ST_UNKNOWN));

		for (i = 0; i < tbl.size(); i++) begin
			if (tbl[i].kind == ROW_CFG) begin
				if (i > 0 && tbl[i-1].kind == ROW_ITEM)
					wait_drained();
				write_reg(tbl[i].idx, tbl[i].val);
			end else begin
				send_meas(tbl[i].item, tbl[i].typed, tbl[i].want);
			end
		end

		// Random phases, each with fresh register values
		phase = 0;
		while (n_items < 1900) begin
			wait_drained();
			if (phase == 2) begin
				// long clean run to saturate the largest required count
				rel      = 2000;
				blk      = 5000;
				req      = 255;
				n_phase  = 280;
				safe_pct = 100;
				idle_tx  = 1'b0;
				idle_rx  = 1'b0;
			end else begin
				case ($urandom_range(0, 4))
					0: rel = 0;
					1: rel = 32767;
					2, 3: rel = $urandom_range(0, 2000);
					default: rel = $urandom_range(0, 32767);
				endcase
				case ($urandom_range(0, 4))
					0: blk = 0;
					1: blk = 32767;
					2, 3: blk = (rel + $urandom_range(1, 3000) > 32767) ? 32767 :
						rel + $urandom_range(1, 3000);
					default: blk = $urandom_range(0, 32767);
				endcase
				case ($urandom_range(0, 4))
					0: req = 1;
					1: req = $urandom_range(13, 255);
					default: req = $urandom_range(1, 12);
				endcase
				n_phase  = $urandom_range(40, 160);
				safe_pct = $urandom_range(50, 95);
				idle_tx  = ($urandom_range(0, 3) != 0);
				idle_rx  = ($urandom_range(0, 3) != 0);
			end
			write_reg(CFG_RELEASE_THR, CfgDataW'(rel));
			write_reg(CFG_BLOCK_THR, CfgDataW'(blk));
			write_reg(CFG_REQ_COUNT, CfgDataW'(req));
			for (i = 0; i < n_phase; i++)
				send_meas(make_meas(safe_pct), 1'b0, ST_UNKNOWN);
			phase++;
		end

		// Drain, then allow for the pipeline latency
		wait_drained();
		repeat (10) @(posedge clk);
		if (state_q.size() != 0) begin
			errors += state_q.size();
			$display("%0t: %0d expected results never arrived", $time, state_q.size());
		end

		$display("Covered %0d measurements over %0d random phases and %0d register writes.",
			n_items, phase, n_writes);
		$display("Matched results: unknown %0d, saturated %0d, unsafe %0d, safe %0d.",
			n_by_state[ST_UNKNOWN], n_by_state[ST_SATURATED],
			n_by_state[ST_UNSAFE], n_by_state[ST_SAFE]);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
